[sv/assert_macros.svh]
// ============================================================================
// Assertion macros
// Shared concurrent assertion wrappers for the RTL.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define ASSERT_NORST(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rstn, prop)
`define ASSERT_NORST(label, clk, prop)
`endif
`endif

[sv/pidw_pkg.sv]
// ============================================================================
// pidw_pkg
// Types, constants and helpers for the palette inverse-distance weighting core.
// ============================================================================
package pidw_pkg;
    localparam int ENTRY_COUNT = 5;
    localparam int IDX_W = 3;
    localparam int SHARE_FRACTION_BITS = 16;
    localparam int SQ_W = 18;
    localparam int RAD_W = 34;             // sq << 16
    localparam int ROOT_W = 17;
    localparam int DEN_W = 17;
    localparam int W_W = 28;               // 2^32 / 26 < 2^28
    localparam int TOT_W = 31;
    localparam int SNUM_W = W_W + SHARE_FRACTION_BITS;
    localparam int SQ_STEPS = RAD_W / 2;   // 17
    localparam int RC_STEPS = 33;          // quotient bits of 2^32 / den
    localparam int SH_STEPS = SNUM_W;      // quotient bits of share
    localparam logic [DEN_W-1:0] OFFSET_Q8 = 17'd26;
    localparam logic [15:0] SHARE_MAX = 16'hFFFF;

    localparam logic [23:0] PAL_RESET [ENTRY_COUNT] = '{
        24'hFFFFFF, 24'hE30022, 24'h3F00FF, 24'hFFE300, 24'h654321
    };

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } rgb_t;

    typedef logic [W_W-1:0] weight_t;
endpackage

[sv/pidw_sqrt_cell.sv]
// ============================================================================
// pidw_sqrt_cell
// One bit-pair step of a restoring integer square root, registered.
// ============================================================================
module pidw_sqrt_cell (
    input  logic                           aclk,
    input  logic                           en,
    input  logic [pidw_pkg::RAD_W-1:0]     rem_in,
    input  logic [pidw_pkg::ROOT_W-1:0]    root_in,
    input  logic [pidw_pkg::RAD_W-1:0]     rad_in,
    output logic [pidw_pkg::RAD_W-1:0]     rem_out,
    output logic [pidw_pkg::ROOT_W-1:0]    root_out,
    output logic [pidw_pkg::RAD_W-1:0]     rad_out
);
    import pidw_pkg::*;

    logic [RAD_W+1:0] rem_sh;
    logic [RAD_W+1:0] trial;
    logic [RAD_W-1:0] rem_next;
    logic [ROOT_W-1:0] root_next;
    logic [RAD_W-1:0] rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [RAD_W-1:0] rad_reg;

    always_comb begin
        rem_sh = {rem_in, rad_in[RAD_W-1 -: 2]};
        trial = {{(RAD_W-ROOT_W){1'b0}}, root_in, 2'b01};
        if (rem_sh >= trial) begin
            rem_next = RAD_W'(rem_sh - trial);
            root_next = {root_in[ROOT_W-2:0], 1'b1};
        end else begin
            rem_next = RAD_W'(rem_sh);
            root_next = {root_in[ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg <= rem_next;
            root_reg <= root_next;
            rad_reg <= {rad_in[RAD_W-3:0], 2'b00};
        end
    end

    assign rem_out = rem_reg;
    assign root_out = root_reg;
    assign rad_out = rad_reg;
endmodule

[sv/pidw_div_cell.sv]
// ============================================================================
// pidw_div_cell
// One restoring-division step: shift in a numerator bit, trial subtract.
// ============================================================================
module pidw_div_cell (
    input  logic                        aclk,
    input  logic                        en,
    input  logic [pidw_pkg::SNUM_W-1:0] num_in,
    input  logic [pidw_pkg::TOT_W:0]    rem_in,
    input  logic [pidw_pkg::SNUM_W-1:0] quo_in,
    input  logic [pidw_pkg::TOT_W-1:0]  dvs_in,
    output logic [pidw_pkg::SNUM_W-1:0] num_out,
    output logic [pidw_pkg::TOT_W:0]    rem_out,
    output logic [pidw_pkg::SNUM_W-1:0] quo_out,
    output logic [pidw_pkg::TOT_W-1:0]  dvs_out
);
    import pidw_pkg::*;

    logic [TOT_W+1:0] rem_sh;
    logic [TOT_W:0] rem_next;
    logic bit_next;
    logic [SNUM_W-1:0] num_reg;
    logic [TOT_W:0] rem_reg;
    logic [SNUM_W-1:0] quo_reg;
    logic [TOT_W-1:0] dvs_reg;

    always_comb begin
        rem_sh = {rem_in, num_in[SNUM_W-1]};
        if (rem_sh >= {2'b00, dvs_in}) begin
            rem_next = (TOT_W+1)'(rem_sh - {2'b00, dvs_in});
            bit_next = 1'b1;
        end else begin
            rem_next = (TOT_W+1)'(rem_sh);
            bit_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            num_reg <= {num_in[SNUM_W-2:0], 1'b0};
            rem_reg <= rem_next;
            quo_reg <= {quo_in[SNUM_W-2:0], bit_next};
            dvs_reg <= dvs_in;
        end
    end

    assign num_out = num_reg;
    assign rem_out = rem_reg;
    assign quo_out = quo_reg;
    assign dvs_out = dvs_reg;
endmodule

[sv/palette_inverse_distance_weights_core.sv]
// ============================================================================
// palette_inverse_distance_weights_core
// Normalized inverse-distance weights of one RGB pixel against five colors.
// ============================================================================
// One pixel transfer in, five result transfers out (entry 0..4, last on 4).
// Five weight lanes run in parallel, each a chain of registered cells:
// squared distance, a 17-cell square root, a 33-cell reciprocal divider.
// The weights are summed, then serialized one entry per cycle, while the
// output is not stalled, into a 44-cell share divider; results leave one per
// cycle under the same condition. A new pixel is accepted while earlier
// pixels are still in the chain, once the serializer will be free for it. The
// whole chain advances only when its final stage can move (global stall).
module palette_inverse_distance_weights_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // pixel_red[7:0], pixel_green[15:8], pixel_blue[23:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // entry_index[2:0], share[18:3], zero fill
    output logic        m_tlast,   // last_entry
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_wdata
);
    import pidw_pkg::*;
`include "assert_macros.svh"

    localparam int WPIPE = 1 + SQ_STEPS + RC_STEPS + 1; // sq, roots, recips, sum
    localparam int SPIPE = SH_STEPS + 1;

    logic [23:0] pal_reg [ENTRY_COUNT];
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ENTRY_COUNT; i++) pal_reg[i] <= PAL_RESET[i];
        end else if (cfg_we && cfg_index < 3'(ENTRY_COUNT)) begin
            pal_reg[cfg_index] <= cfg_wdata;
        end
    end

    // serializer / output state
    logic [IDX_W-1:0] ser_cnt_reg;
    logic ser_busy_reg;
    logic [SH_STEPS-1:0] sv_reg;            // valid per share stage
    logic [IDX_W-1:0] sidx_reg [SH_STEPS];
    logic [WPIPE-1:0] wv_reg;               // valid per weight stage
    logic adv;                              // whole chain advance
    logic wstage_take;

    // output register with stall: advance when output free
    assign adv = !m_tvalid || m_tready;
    // pixel accepted only when serializer will be free as the pixel arrives;
    // a new pixel waits until gap_reg has counted down to zero
    logic [2:0] gap_reg;
    assign s_tready = adv && (gap_reg == 3'd0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gap_reg <= '0;
        end else if (adv) begin
            if (s_tvalid && s_tready) gap_reg <= 3'(ENTRY_COUNT - 1);
            else if (gap_reg != 3'd0) gap_reg <= gap_reg - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) wv_reg <= '0;
        else if (adv) wv_reg <= {wv_reg[WPIPE-2:0], s_tvalid && s_tready};
    end

    // lane chains
    logic [RAD_W-1:0] rad0 [ENTRY_COUNT];
    logic [RAD_W-1:0] rem_c [ENTRY_COUNT][SQ_STEPS+1];
    logic [ROOT_W-1:0] root_c [ENTRY_COUNT][SQ_STEPS+1];
    logic [RAD_W-1:0] rad_c [ENTRY_COUNT][SQ_STEPS+1];
    logic [SNUM_W-1:0] rn_c [ENTRY_COUNT][RC_STEPS+1];
    logic [TOT_W:0] rr_c [ENTRY_COUNT][RC_STEPS+1];
    logic [SNUM_W-1:0] rq_c [ENTRY_COUNT][RC_STEPS+1];
    logic [TOT_W-1:0] rd_c [ENTRY_COUNT][RC_STEPS+1];
    weight_t w_reg [ENTRY_COUNT];
    weight_t wl_reg [ENTRY_COUNT];
    logic [TOT_W-1:0] tot_reg;

    rgb_t px;
    assign px = '{r: s_tdata[7:0], g: s_tdata[15:8], b: s_tdata[23:16]};

    for (genvar e = 0; e < ENTRY_COUNT; e++) begin : g_lane
        logic [7:0] dr, dg, db;
        logic [15:0] sr, sg, sb;
        logic [SQ_W-1:0] sq_next;
        logic [SQ_W-1:0] sq_reg;
        always_comb begin
            dr = (px.r >= pal_reg[e][23:16]) ? px.r - pal_reg[e][23:16]
                                             : pal_reg[e][23:16] - px.r;
            dg = (px.g >= pal_reg[e][15:8]) ? px.g - pal_reg[e][15:8]
                                            : pal_reg[e][15:8] - px.g;
            db = (px.b >= pal_reg[e][7:0]) ? px.b - pal_reg[e][7:0]
                                           : pal_reg[e][7:0] - px.b;
            sr = 16'(dr) * 16'(dr);
            sg = 16'(dg) * 16'(dg);
            sb = 16'(db) * 16'(db);
            sq_next = SQ_W'(sr) + SQ_W'(sg) + SQ_W'(sb);
        end
        always_ff @(posedge aclk) if (adv) sq_reg <= sq_next;
        assign rad0[e] = {sq_reg, 16'h0000};
        assign rem_c[e][0] = '0;
        assign root_c[e][0] = '0;
        assign rad_c[e][0] = rad0[e];
        for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
            pidw_sqrt_cell u_cell (
                .aclk(aclk), .en(adv),
                .rem_in(rem_c[e][k]), .root_in(root_c[e][k]), .rad_in(rad_c[e][k]),
                .rem_out(rem_c[e][k+1]), .root_out(root_c[e][k+1]),
                .rad_out(rad_c[e][k+1])
            );
        end
        // 2^32 / (root + 26): numerator 2^32 left-aligned in the 33 low steps
        assign rn_c[e][0] = SNUM_W'(64'h1_0000_0000) << (SNUM_W - RC_STEPS);
        assign rr_c[e][0] = '0;
        assign rq_c[e][0] = '0;
        assign rd_c[e][0] = TOT_W'(root_c[e][SQ_STEPS] + OFFSET_Q8);
        for (genvar k = 0; k < RC_STEPS; k++) begin : g_rc
            pidw_div_cell u_cell (
                .aclk(aclk), .en(adv),
                .num_in(rn_c[e][k]), .rem_in(rr_c[e][k]), .quo_in(rq_c[e][k]),
                .dvs_in(rd_c[e][k]),
                .num_out(rn_c[e][k+1]), .rem_out(rr_c[e][k+1]),
                .quo_out(rq_c[e][k+1]), .dvs_out(rd_c[e][k+1])
            );
        end
        assign w_reg[e] = W_W'(rq_c[e][RC_STEPS]);
        always_ff @(posedge aclk) if (adv) wl_reg[e] <= w_reg[e];
    end

    always_ff @(posedge aclk) begin
        if (adv) tot_reg <= TOT_W'(w_reg[0]) + TOT_W'(w_reg[1]) + TOT_W'(w_reg[2])
                          + TOT_W'(w_reg[3]) + TOT_W'(w_reg[4]);
    end

    // serializer: holds the five weights and total while their entries are fed out
    weight_t hw_reg [ENTRY_COUNT];
    logic [TOT_W-1:0] htot_reg;
    assign wstage_take = wv_reg[WPIPE-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ser_busy_reg <= 1'b0;
            ser_cnt_reg <= '0;
        end else if (adv) begin
            if (wstage_take) begin
                ser_busy_reg <= 1'b1;
                ser_cnt_reg <= '0;
            end else if (ser_busy_reg) begin
                if (ser_cnt_reg == IDX_W'(ENTRY_COUNT - 1)) ser_busy_reg <= 1'b0;
                else ser_cnt_reg <= ser_cnt_reg + 1'b1;
            end
        end
    end
    always_ff @(posedge aclk) begin
        if (adv && wstage_take) begin
            for (int i = 0; i < ENTRY_COUNT; i++) hw_reg[i] <= wl_reg[i];
            htot_reg <= tot_reg;
        end
    end

    logic [SNUM_W-1:0] sn_c [SPIPE];
    logic [TOT_W:0] sr_c [SPIPE];
    logic [SNUM_W-1:0] sq_c [SPIPE];
    logic [TOT_W-1:0] sd_c [SPIPE];
    assign sn_c[0] = {hw_reg[ser_cnt_reg], {SHARE_FRACTION_BITS{1'b0}}};
    assign sr_c[0] = '0;
    assign sq_c[0] = '0;
    assign sd_c[0] = htot_reg;
    for (genvar k = 0; k < SH_STEPS; k++) begin : g_sh
        pidw_div_cell u_cell (
            .aclk(aclk), .en(adv),
            .num_in(sn_c[k]), .rem_in(sr_c[k]), .quo_in(sq_c[k]), .dvs_in(sd_c[k]),
            .num_out(sn_c[k+1]), .rem_out(sr_c[k+1]), .quo_out(sq_c[k+1]),
            .dvs_out(sd_c[k+1])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) sv_reg <= '0;
        else if (adv) sv_reg <= {sv_reg[SH_STEPS-2:0], ser_busy_reg};
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            sidx_reg[0] <= ser_cnt_reg;
            for (int i = 1; i < SH_STEPS; i++) sidx_reg[i] <= sidx_reg[i-1];
        end
    end

    // final stage is the output register
    logic [15:0] share_sat;
    logic [IDX_W-1:0] oidx_reg;
    logic [15:0] oshare_reg;
    logic ovalid_reg;
    assign share_sat = (sq_c[SH_STEPS][SNUM_W-1:16] != '0) ? SHARE_MAX
                       : sq_c[SH_STEPS][15:0];
    always_ff @(posedge aclk) begin
        if (!aresetn) ovalid_reg <= 1'b0;
        else if (adv) ovalid_reg <= sv_reg[SH_STEPS-1];
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            oidx_reg <= sidx_reg[SH_STEPS-1];
            oshare_reg <= share_sat;
        end
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata = {5'b0, oshare_reg, oidx_reg};
    assign m_tlast = (oidx_reg == IDX_W'(ENTRY_COUNT - 1));

    `ASSERT_IMPL(a_idx_range, aclk, aresetn, m_tvalid |-> oidx_reg < IDX_W'(ENTRY_COUNT))
    `ASSERT_IMPL(a_stall_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    `ASSERT_IMPL(a_ser_cnt, aclk, aresetn, ser_busy_reg |-> ser_cnt_reg < IDX_W'(ENTRY_COUNT))
endmodule

[test/tb_palette_inverse_distance_weights_core.sv]
// ----------------------------------------------------------------------------
// tb_palette_inverse_distance_weights_core
// Drives RGB pixels into the palette weighting core and checks every entry
// share against an in-bench predictor, with random stalls on both sides and
// palette rewrites between phases.
// ----------------------------------------------------------------------------
module tb_palette_inverse_distance_weights_core;
    timeunit 1ns;
    timeprecision 1ps;
    import pidw_pkg::*;

    typedef struct {
        logic [IDX_W-1:0] index;
        logic [15:0]      share;
        logic             last;
    } share_item_t;

    class share_board;
        logic [23:0] palette [ENTRY_COUNT];
        share_item_t pending [$];
        int          errors;

        function new();
            for (int i = 0; i < ENTRY_COUNT; i++) palette[i] = PAL_RESET[i];
            errors = 0;
        endfunction

        function automatic logic [63:0] root_of(logic [63:0] v);
            logic [63:0] root;
            logic [63:0] b;
            root = 0;
            b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= root + b) begin
                    v = v - (root + b);
                    root = (root >> 1) + b;
                end else begin
                    root >>= 1;
                end
                b >>= 2;
            end
            return root;
        endfunction

        function void note_pixel(logic [23:0] px);
            logic [63:0] w [ENTRY_COUNT];
            logic [63:0] tot;
            logic [63:0] s;
            int dr, dg, db;
            share_item_t it;
            tot = 0;
            for (int i = 0; i < ENTRY_COUNT; i++) begin
                dr = int'(px[7:0]) - int'(palette[i][23:16]);
                dg = int'(px[15:8]) - int'(palette[i][15:8]);
                db = int'(px[23:16]) - int'(palette[i][7:0]);
                w[i] = (64'd1 << 32) /
                       (root_of(64'(dr*dr + dg*dg + db*db) << 16) + 64'd26);
                tot += w[i];
            end
            for (int i = 0; i < ENTRY_COUNT; i++) begin
                s = (w[i] << SHARE_FRACTION_BITS) / tot;
                it.index = IDX_W'(i);
                it.share = (s > 64'hFFFF) ? SHARE_MAX : s[15:0];
                it.last  = (i == ENTRY_COUNT - 1);
                pending.insert(pending.size(), it);
            end
        endfunction

        function void check_share(logic [23:0] data, logic last);
            share_item_t e;
            if (pending.size() == 0) begin
                $error("unexpected result transfer data=%h", data);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (data[2:0] !== e.index) begin
                $error("entry_index exp %0d got %0d", e.index, data[2:0]); errors++;
            end
            if (data[18:3] !== e.share) begin
                $error("share exp %0d got %0d", e.share, data[18:3]); errors++;
            end
            if (last !== e.last) begin
                $error("last_entry exp %0b got %0b", e.last, last); errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // pixel_red[7:0], pixel_green[15:8], pixel_blue[23:16]
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // entry_index[2:0], share[18:3], zero fill
    logic        m_tlast;   // last_entry
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [23:0] cfg_wdata;

    share_board board;
    bit         stall_enable;
    longint     cycle_count;

    palette_inverse_distance_weights_core dut (.*);

    initial begin
        aclk = 0;
        forever #6 aclk = ~aclk;
    end

    function automatic int gap_len();
        if ($urandom_range(0, 9) < 7) return $urandom_range(0, 2);
        return $urandom_range(3, 30);
    endfunction

    // tvalid stays high between back-to-back pixels; drain() drops it
    task automatic send_pixel(logic [23:0] px);
        int g;
        g = stall_enable ? gap_len() : 0;
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        do @(posedge aclk); while (!s_tready);
        board.note_pixel(px);
    endtask

    task automatic write_palette(logic [2:0] idx, logic [23:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        if (idx < ENTRY_COUNT) board.palette[idx] = val;
        @(posedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (150) @(posedge aclk);
    endtask

    task automatic random_pixels(int n);
        repeat (n) begin
            case ($urandom_range(0, 3))
                0: send_pixel(board.palette[$urandom_range(0, ENTRY_COUNT - 1)]
                              ^ 24'($urandom_range(0, 3)));
                default: send_pixel(24'($urandom));
            endcase
        end
    endtask

    // result side: random backpressure while stall_enable is set
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) board.check_share(m_tdata, m_tlast);
            m_tready <= !stall_enable || ($urandom_range(0, 9) < 7);
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > 400000) begin
            $display("tb_palette_inverse_distance_weights_core NOT OK");
            $finish;
        end
    end

    initial begin
        board        = new();
        cycle_count  = 0;
        stall_enable = 0;
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_wdata    = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed, reset palette
        send_pixel(24'h000000);
        send_pixel(24'hFFFFFF);
        send_pixel(24'hFFFFFF);     // exact match on white
        send_pixel(24'h2200E3);     // exact match entry 1
        send_pixel(24'hFF003F);
        send_pixel(24'h00E3FF);
        send_pixel(24'h214365);
        send_pixel(24'hAA55AA);
        send_pixel(24'h55AA55);
        drain();

        // extremes of the palette, unknown index ignored
        write_palette(3'd0, 24'h000000);
        write_palette(3'd1, 24'h000000);
        write_palette(3'd2, 24'hFFFFFF);
        write_palette(3'd3, 24'hFFFFFF);
        write_palette(3'd4, 24'h808080);
        write_palette(3'd5, 24'h123456);
        write_palette(3'd7, 24'hABCDEF);
        send_pixel(24'h000000);
        send_pixel(24'hFFFFFF);
        send_pixel(24'h808080);
        send_pixel(24'h7F7F7F);
        send_pixel(24'hFF00FF);
        drain();

        stall_enable = 1;
        random_pixels(60);
        drain();
        for (int i = 0; i < ENTRY_COUNT; i++) write_palette(3'(i), 24'($urandom));
        random_pixels(70);
        stall_enable = 0;
        random_pixels(10);
        drain();
        for (int i = 0; i < ENTRY_COUNT; i++) write_palette(3'(i), PAL_RESET[i]);
        stall_enable = 1;
        random_pixels(60);
        drain();

        if (board.errors == 0) begin
            $display("tb_palette_inverse_distance_weights_core OK");
        end else begin
            $display("tb_palette_inverse_distance_weights_core NOT OK");
        end
        $finish;
    end
endmodule
